FILE: design/hms_pkg.sv
`timescale 1ns / 1ps
package hms_pkg;

	localparam int WORD_W = 32;
	localparam int FRAC_W = 28;
	localparam int CFG_W = 31;
	localparam int IDX_W = 3;

	localparam int SQ_W = 2 * WORD_W;
	localparam int HALF_W = SQ_W / 2;
	localparam int PP_W = CFG_W + HALF_W;
	localparam int BP_W = CFG_W + WORD_W;
	localparam int AP_W = CFG_W + SQ_W;
	localparam int AQ_W = AP_W - 2 * FRAC_W + 1;
	localparam int YB_W = BP_W - FRAC_W + 2;
	localparam int SUM_W = AQ_W + 2;

	localparam logic [IDX_W-1:0] REG_A_LOWER = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_A_UPPER = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_B_LOWER = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_B_UPPER = IDX_W'(3);

	// 1.4 and 0.3, rounded down and up
	localparam logic [CFG_W-1:0] A_LOWER_RST = CFG_W'((64'd14 << FRAC_W) / 64'd10);
	localparam logic [CFG_W-1:0] A_UPPER_RST = CFG_W'(((64'd14 << FRAC_W) + 64'd9) / 64'd10);
	localparam logic [CFG_W-1:0] B_LOWER_RST = CFG_W'((64'd3 << FRAC_W) / 64'd10);
	localparam logic [CFG_W-1:0] B_UPPER_RST = CFG_W'(((64'd3 << FRAC_W) + 64'd9) / 64'd10);

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

	typedef struct packed {
		logic [SQ_W-1:0] sq_lo;
		logic [SQ_W-1:0] sq_hi;
		logic [BP_W-1:0] bl_prod;
		logic [BP_W-1:0] bu_prod;
		logic xl_neg;
		logic xu_neg;
		logic [WORD_W-1:0] y_lo;
		logic [WORD_W-1:0] y_hi;
	} sq_data_t;

	typedef struct packed {
		logic [AQ_W-1:0] ax_hi;
		logic [AQ_W-1:0] ax_lo;
		logic [YB_W-1:0] ny_lo;
		logic [YB_W-1:0] ny_hi;
		logic [WORD_W-1:0] y_lo;
		logic [WORD_W-1:0] y_hi;
	} scaled_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic clip;
	} sat_t;

	function automatic logic [WORD_W-1:0] magnitude(input logic [WORD_W-1:0] v);
		return v[WORD_W-1] ? (~v + WORD_W'(1)) : v;
	endfunction

	function automatic sat_t saturate(input logic [SUM_W-1:0] v);
		sat_t r;
		logic [SUM_W-WORD_W:0] head;
		head = v[SUM_W-1:WORD_W-1];
		if (head == '0 || head == '1) begin
			r.word = v[WORD_W-1:0];
			r.clip = 1'b0;
		end else begin
			r.word = {v[SUM_W-1], {(WORD_W-1){~v[SUM_W-1]}}};
			r.clip = 1'b1;
		end
		return r;
	endfunction

endpackage

FILE: design/hms_front.sv
`timescale 1ns / 1ps
module hms_front import hms_pkg::*; (
	input  logic              clk,
	input  stage_en_t         en,
	input  logic [WORD_W-1:0] x_lower,
	input  logic [WORD_W-1:0] x_upper,
	input  logic [WORD_W-1:0] y_lower,
	input  logic [WORD_W-1:0] y_upper,
	input  logic [CFG_W-1:0]  b_lower,
	input  logic [CFG_W-1:0]  b_upper,
	output sq_data_t          sq_s2
);

	logic [WORD_W-1:0] ml, mu, sq_lo_m, sq_hi_m;
	logic xu_nonpos;

	logic [WORD_W-1:0] sq_lo_m_s1, sq_hi_m_s1, ml_s1, mu_s1, y_lo_s1, y_hi_s1;
	logic xl_neg_s1, xu_neg_s1;

	logic [CFG_W-1:0] bl_sel, bu_sel;
	sq_data_t sq_d;

	// square operands by sign case of x
	always_comb begin
		ml = magnitude(x_lower);
		mu = magnitude(x_upper);
		xu_nonpos = x_upper[WORD_W-1] || (x_upper == '0);
		if (!x_lower[WORD_W-1]) begin
			sq_lo_m = ml;
			sq_hi_m = mu;
		end else if (xu_nonpos) begin
			sq_lo_m = mu;
			sq_hi_m = ml;
		end else begin
			sq_lo_m = '0;
			sq_hi_m = (ml > mu) ? ml : mu;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			sq_lo_m_s1 <= sq_lo_m;
			sq_hi_m_s1 <= sq_hi_m;
			ml_s1 <= ml;
			mu_s1 <= mu;
			xl_neg_s1 <= x_lower[WORD_W-1];
			xu_neg_s1 <= x_upper[WORD_W-1];
			y_lo_s1 <= y_lower;
			y_hi_s1 <= y_upper;
		end
	end

	always_comb begin
		bl_sel = xl_neg_s1 ? b_upper : b_lower;
		bu_sel = xu_neg_s1 ? b_lower : b_upper;
		sq_d.sq_lo = sq_lo_m_s1 * sq_lo_m_s1;
		sq_d.sq_hi = sq_hi_m_s1 * sq_hi_m_s1;
		sq_d.bl_prod = bl_sel * ml_s1;
		sq_d.bu_prod = bu_sel * mu_s1;
		sq_d.xl_neg = xl_neg_s1;
		sq_d.xu_neg = xu_neg_s1;
		sq_d.y_lo = y_lo_s1;
		sq_d.y_hi = y_hi_s1;
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			sq_s2 <= sq_d;
		end
	end

endmodule

FILE: design/hms_scale.sv
`timescale 1ns / 1ps
module hms_scale import hms_pkg::*; (
	input  logic             clk,
	input  stage_en_t        en,
	input  logic [CFG_W-1:0] a_lower,
	input  logic [CFG_W-1:0] a_upper,
	input  sq_data_t         sq_s2,
	output scaled_t          sc_s4
);

	logic [PP_W-1:0] pa_lo, pa_hi, pb_lo, pb_hi;
	logic [YB_W-2:0] bl_q, bu_q;
	logic [YB_W-1:0] ny_lo, ny_hi;

	logic [PP_W-1:0] pa_lo_s3, pa_hi_s3, pb_lo_s3, pb_hi_s3;
	logic [YB_W-1:0] ny_lo_s3, ny_hi_s3;
	logic [WORD_W-1:0] y_lo_s3, y_hi_s3;

	logic [AP_W-1:0] ap, bp;
	scaled_t sc_d;

	// a times square as two half-width partial products; y bounds rounded
	always_comb begin
		pa_lo = a_upper * sq_s2.sq_hi[HALF_W-1:0];
		pa_hi = a_upper * sq_s2.sq_hi[SQ_W-1:HALF_W];
		pb_lo = a_lower * sq_s2.sq_lo[HALF_W-1:0];
		pb_hi = a_lower * sq_s2.sq_lo[SQ_W-1:HALF_W];
		bl_q = (YB_W-1)'(sq_s2.bl_prod[BP_W-1:FRAC_W])
			+ (YB_W-1)'(sq_s2.xl_neg && (|sq_s2.bl_prod[FRAC_W-1:0]));
		bu_q = (YB_W-1)'(sq_s2.bu_prod[BP_W-1:FRAC_W])
			+ (YB_W-1)'(!sq_s2.xu_neg && (|sq_s2.bu_prod[FRAC_W-1:0]));
		ny_lo = sq_s2.xl_neg ? (YB_W'(0) - {1'b0, bl_q}) : {1'b0, bl_q};
		ny_hi = sq_s2.xu_neg ? (YB_W'(0) - {1'b0, bu_q}) : {1'b0, bu_q};
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			pa_lo_s3 <= pa_lo;
			pa_hi_s3 <= pa_hi;
			pb_lo_s3 <= pb_lo;
			pb_hi_s3 <= pb_hi;
			ny_lo_s3 <= ny_lo;
			ny_hi_s3 <= ny_hi;
			y_lo_s3 <= sq_s2.y_lo;
			y_hi_s3 <= sq_s2.y_hi;
		end
	end

	// join partials, drop fraction bits; upper product of a rounds up
	always_comb begin
		ap = AP_W'(pa_lo_s3) + (AP_W'(pa_hi_s3) << HALF_W);
		bp = AP_W'(pb_lo_s3) + (AP_W'(pb_hi_s3) << HALF_W);
		sc_d.ax_hi = AQ_W'(ap[AP_W-1:2*FRAC_W]) + AQ_W'(|ap[2*FRAC_W-1:0]);
		sc_d.ax_lo = AQ_W'(bp[AP_W-1:2*FRAC_W]);
		sc_d.ny_lo = ny_lo_s3;
		sc_d.ny_hi = ny_hi_s3;
		sc_d.y_lo = y_lo_s3;
		sc_d.y_hi = y_hi_s3;
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			sc_s4 <= sc_d;
		end
	end

endmodule

FILE: design/hms_final.sv
`timescale 1ns / 1ps
module hms_final import hms_pkg::*; (
	input  logic              clk,
	input  stage_en_t         en,
	input  scaled_t           sc_s4,
	output logic [WORD_W-1:0] next_x_lower,
	output logic [WORD_W-1:0] next_x_upper,
	output logic [WORD_W-1:0] next_y_lower,
	output logic [WORD_W-1:0] next_y_upper,
	output logic              saturated
);

	localparam logic [SUM_W-1:0] ONE = SUM_W'(1) << FRAC_W;

	logic [SUM_W-1:0] sx_lo, sx_hi, sy_lo, sy_hi;
	sat_t r_xl, r_xu, r_yl, r_yu;

	logic [WORD_W-1:0] nxl_s5, nxu_s5, nyl_s5, nyu_s5;
	logic sat_s5;

	always_comb begin
		sx_lo = ONE - SUM_W'(sc_s4.ax_hi)
			+ {{(SUM_W-WORD_W){sc_s4.y_lo[WORD_W-1]}}, sc_s4.y_lo};
		sx_hi = ONE - SUM_W'(sc_s4.ax_lo)
			+ {{(SUM_W-WORD_W){sc_s4.y_hi[WORD_W-1]}}, sc_s4.y_hi};
		sy_lo = {{(SUM_W-YB_W){sc_s4.ny_lo[YB_W-1]}}, sc_s4.ny_lo};
		sy_hi = {{(SUM_W-YB_W){sc_s4.ny_hi[YB_W-1]}}, sc_s4.ny_hi};
		r_xl = saturate(sx_lo);
		r_xu = saturate(sx_hi);
		r_yl = saturate(sy_lo);
		r_yu = saturate(sy_hi);
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			nxl_s5 <= r_xl.word;
			nxu_s5 <= r_xu.word;
			nyl_s5 <= r_yl.word;
			nyu_s5 <= r_yu.word;
			sat_s5 <= r_xl.clip | r_xu.clip | r_yl.clip | r_yu.clip;
		end
	end

	assign next_x_lower = nxl_s5;
	assign next_x_upper = nxu_s5;
	assign next_y_lower = nyl_s5;
	assign next_y_upper = nyu_s5;
	assign saturated = sat_s5;

endmodule

FILE: design/interval_henon_map_step.sv
// an accepted item moves through the stage registers s1 to s5 in order,
// and out_valid and the result come from s5
// throughput: one item per cycle while out_ready holds; five register stages,
// each stalls only when the stage after it is full and not moving
// reset: asynchronous, clears all stage valid bits and loads a and b
// with 1.4 and 0.3 (lower rounded down, upper rounded up)
`timescale 1ns / 1ps
module interval_henon_map_step import hms_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [WORD_W-1:0] x_lower,
	input  logic [WORD_W-1:0] x_upper,
	input  logic [WORD_W-1:0] y_lower,
	input  logic [WORD_W-1:0] y_upper,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WORD_W-1:0] next_x_lower,
	output logic [WORD_W-1:0] next_x_upper,
	output logic [WORD_W-1:0] next_y_lower,
	output logic [WORD_W-1:0] next_y_upper,
	output logic              saturated,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	logic [CFG_W-1:0] a_lower_q, a_upper_q, b_lower_q, b_upper_q;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	stage_en_t en;
	sq_data_t sq_s2;
	scaled_t sc_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_lower_q <= A_LOWER_RST;
			a_upper_q <= A_UPPER_RST;
			b_lower_q <= B_LOWER_RST;
			b_upper_q <= B_UPPER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_A_LOWER: a_lower_q <= cfg_data;
				REG_A_UPPER: a_upper_q <= cfg_data;
				REG_B_LOWER: b_lower_q <= cfg_data;
				REG_B_UPPER: b_upper_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage loads when it is empty or its item moves on
	always_comb begin
		en.s5 = !v_s5 || out_ready;
		en.s4 = !v_s4 || en.s5;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= in_valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4;
		end
	end

	assign in_ready = en.s1;
	assign out_valid = v_s5;

	hms_front u_front (
		.clk     (clk),
		.en      (en),
		.x_lower (x_lower),
		.x_upper (x_upper),
		.y_lower (y_lower),
		.y_upper (y_upper),
		.b_lower (b_lower_q),
		.b_upper (b_upper_q),
		.sq_s2   (sq_s2)
	);

	hms_scale u_scale (
		.clk     (clk),
		.en      (en),
		.a_lower (a_lower_q),
		.a_upper (a_upper_q),
		.sq_s2   (sq_s2),
		.sc_s4   (sc_s4)
	);

	hms_final u_final (
		.clk          (clk),
		.en           (en),
		.sc_s4        (sc_s4),
		.next_x_lower (next_x_lower),
		.next_x_upper (next_x_upper),
		.next_y_lower (next_y_lower),
		.next_y_upper (next_y_upper),
		.saturated    (saturated)
	);

endmodule

FILE: design/hms_checker.sv
`timescale 1ns / 1ps
module hms_checker import hms_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [WORD_W-1:0] x_lower,
	input logic              out_valid,
	input logic              out_ready,
	input logic [WORD_W-1:0] next_x_lower,
	input logic [WORD_W-1:0] next_x_upper,
	input logic [WORD_W-1:0] next_y_lower,
	input logic [WORD_W-1:0] next_y_upper,
	input logic              saturated
);

	localparam logic [WORD_W-1:0] W_MIN = {1'b1, {(WORD_W-1){1'b0}}};
	localparam logic [WORD_W-1:0] W_MAX = {1'b0, {(WORD_W-1){1'b1}}};

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(next_x_lower)
			&& $stable(next_x_upper) && $stable(next_y_lower)
			&& $stable(next_y_upper) && $stable(saturated))
		else $error("result item changed while stalled");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
			next_x_lower == W_MIN || next_x_lower == W_MAX
			|| next_x_upper == W_MIN || next_x_upper == W_MAX
			|| next_y_lower == W_MIN || next_y_lower == W_MAX
			|| next_y_upper == W_MIN || next_y_upper == W_MAX)
		else $error("saturated flag without a clipped bound");

	a_empty_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid right after reset");

	a_latency_sign: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && out_ready && !x_lower[WORD_W-1]
			##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready
		|=> out_valid && !next_y_lower[WORD_W-1])
		else $error("item lost or lower y bound negative for nonnegative x");

endmodule

bind interval_henon_map_step hms_checker u_hms_checker (.*);

FILE: tb/interval_henon_map_step_test.sv
`timescale 1ns / 1ps
module interval_henon_map_step_test;
	import hms_pkg::*;

	typedef struct packed {
		logic [WORD_W-1:0] xl;
		logic [WORD_W-1:0] xu;
		logic [WORD_W-1:0] yl;
		logic [WORD_W-1:0] yu;
	} box_t;

	typedef struct packed {
		logic [WORD_W-1:0] nx_lo;
		logic [WORD_W-1:0] nx_hi;
		logic [WORD_W-1:0] ny_lo;
		logic [WORD_W-1:0] ny_hi;
		logic              sat;
	} enclosure_t;

	typedef struct packed {
		box_t       box;
		logic       known;
		enclosure_t want;
	} probe_t;

	localparam logic [WORD_W-1:0] ZERO_Q     = '0;
	localparam logic [WORD_W-1:0] MIN_Q      = {1'b1, {(WORD_W - 1){1'b0}}};
	localparam logic [WORD_W-1:0] MAX_Q      = ~MIN_Q;
	localparam logic [WORD_W-1:0] ALL_ONES_Q = '1;
	localparam logic [WORD_W-1:0] ONE_Q      = WORD_W'(1) << FRAC_W;
	localparam logic [WORD_W-1:0] HALF_Q     = WORD_W'(1) << (FRAC_W - 1);
	localparam logic [WORD_W-1:0] NEG_ONE_Q  = -ONE_Q;
	localparam logic [WORD_W-1:0] NEG_HALF_Q = -HALF_Q;
	localparam logic [CFG_W-1:0]  CFG_MAX    = '1;
	localparam logic [IDX_W-1:0]  REG_UNUSED_FIRST = REG_B_UPPER + IDX_W'(1);
	localparam longint WORD_HI = (longint'(1) << (WORD_W - 1)) - 1;
	localparam longint WORD_LO = -WORD_HI - 1;
	localparam longint ONE_L   = longint'(1) << FRAC_W;
	localparam int CHOKE_CYCLES = 60;
	localparam int DRAIN_CYCLES = 10;
	localparam int SETTLE_LIMIT = 5000;

	localparam int PROBE_COUNT = 20;
	localparam probe_t DIRECTED_PROBES [PROBE_COUNT] = '{
		// the first four are point boxes with an enclosure written out
		'{'{ZERO_Q, ZERO_Q, ZERO_Q, ZERO_Q}, 1'b1,
			'{ONE_Q, ONE_Q, ZERO_Q, ZERO_Q, 1'b0}},
		'{'{ZERO_Q, ZERO_Q, MAX_Q, MAX_Q}, 1'b1,
			'{MAX_Q, MAX_Q, ZERO_Q, ZERO_Q, 1'b1}},
		'{'{ZERO_Q, ZERO_Q, MIN_Q, MIN_Q}, 1'b1,
			'{32'h9000_0000, 32'h9000_0000, ZERO_Q, ZERO_Q, 1'b0}},
		'{'{MIN_Q, MIN_Q, ZERO_Q, ZERO_Q}, 1'b1,
			'{MIN_Q, MIN_Q, 32'hD999_9998, 32'hD999_99A0, 1'b1}},
		'{'{ONE_Q, ONE_Q, ZERO_Q, ZERO_Q}, 1'b0, '0},
		'{'{MAX_Q, MAX_Q, MAX_Q, MAX_Q}, 1'b0, '0},
		'{'{MIN_Q, MAX_Q, MIN_Q, MAX_Q}, 1'b0, '0},
		'{'{NEG_ONE_Q, NEG_HALF_Q, ZERO_Q, ZERO_Q}, 1'b0, '0},
		'{'{NEG_HALF_Q, ONE_Q, ZERO_Q, ZERO_Q}, 1'b0, '0},
		'{'{NEG_ONE_Q, HALF_Q, ZERO_Q, ZERO_Q}, 1'b0, '0},
		'{'{ONE_Q, NEG_ONE_Q, ZERO_Q, ZERO_Q}, 1'b0, '0},
		'{'{ZERO_Q, ONE_Q, HALF_Q, NEG_HALF_Q}, 1'b0, '0},
		'{'{NEG_ONE_Q, ZERO_Q, ZERO_Q, ZERO_Q}, 1'b0, '0},
		'{'{ALL_ONES_Q, ALL_ONES_Q, ZERO_Q, ZERO_Q}, 1'b0, '0},
		'{'{32'h0000_0001, 32'h0000_0001, ZERO_Q, ZERO_Q}, 1'b0, '0},
		'{'{32'h0A18_9375, 32'h0A3D_70A4, 32'h02E1_47AE, 32'h030A_3D71}, 1'b0, '0},
		'{'{MIN_Q, MIN_Q, MAX_Q, MIN_Q}, 1'b0, '0},
		'{'{MAX_Q, MIN_Q, MIN_Q, MAX_Q}, 1'b0, '0},
		'{'{32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555}, 1'b0, '0},
		'{'{32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA}, 1'b0, '0}
	};

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [WORD_W-1:0] x_lower;
	logic [WORD_W-1:0] x_upper;
	logic [WORD_W-1:0] y_lower;
	logic [WORD_W-1:0] y_upper;
	logic              out_valid;
	logic              out_ready;
	logic [WORD_W-1:0] next_x_lower;
	logic [WORD_W-1:0] next_x_upper;
	logic [WORD_W-1:0] next_y_lower;
	logic [WORD_W-1:0] next_y_upper;
	logic              saturated;
	logic              cfg_we;
	logic [IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]  cfg_data;

	logic [CFG_W-1:0] a_lo_q;
	logic [CFG_W-1:0] a_hi_q;
	logic [CFG_W-1:0] b_lo_q;
	logic [CFG_W-1:0] b_hi_q;

	enclosure_t pending_enclosures [$];
	int         fail_count = 0;
	int         boxes_sent = 0;
	int         boxes_checked = 0;
	int         clipped_seen = 0;
	int         settings_used = 0;
	bit         calm = 1'b0;
	bit         choke_rx = 1'b0;

	interval_henon_map_step u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.x_lower      (x_lower),
		.x_upper      (x_upper),
		.y_lower      (y_lower),
		.y_upper      (y_upper),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.next_x_lower (next_x_lower),
		.next_x_upper (next_x_upper),
		.next_y_lower (next_y_lower),
		.next_y_upper (next_y_upper),
		.saturated    (saturated),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

	// exact product shifted down by s, rounded up when asked
	function automatic longint scale_product(input logic [63:0] p, input logic [63:0] q,
			input int s, input bit up);
		logic [127:0] prod;
		logic [127:0] rem_mask;
		prod = 128'(p) * 128'(q);
		rem_mask = (128'd1 << s) - 128'd1;
		return longint'(prod >> s) + ((up && (prod & rem_mask) != 0) ? 1 : 0);
	endfunction

	function automatic sat_t clamp_word(input longint v);
		sat_t r;
		r.clip = 1'b1;
		if (v > WORD_HI)
			r.word = MAX_Q;
		else if (v < WORD_LO)
			r.word = MIN_Q;
		else begin
			r.word = WORD_W'(v);
			r.clip = 1'b0;
		end
		return r;
	endfunction

	function automatic enclosure_t henon_enclose(input box_t b);
		longint xl, xu, yl, yu;
		longint nxl, nxu, nyl, nyu;
		logic [63:0] ml, mu, mx, sq_lo, sq_hi;
		sat_t c0, c1, c2, c3;
		enclosure_t r;
		xl = $signed(b.xl);
		xu = $signed(b.xu);
		yl = $signed(b.yl);
		yu = $signed(b.yu);
		ml = (xl < 0) ? 64'(-xl) : 64'(xl);
		mu = (xu < 0) ? 64'(-xu) : 64'(xu);
		// square of x: by sign of the interval
		if (xl >= 0) begin
			sq_lo = ml * ml;
			sq_hi = mu * mu;
		end else if (xu <= 0) begin
			sq_lo = mu * mu;
			sq_hi = ml * ml;
		end else begin
			mx = (ml > mu) ? ml : mu;
			sq_lo = '0;
			sq_hi = mx * mx;
		end
		nxl = ONE_L - scale_product(64'(a_hi_q), sq_hi, 2 * FRAC_W, 1'b1) + yl;
		nxu = ONE_L - scale_product(64'(a_lo_q), sq_lo, 2 * FRAC_W, 1'b0) + yu;
		if (xl >= 0)
			nyl = scale_product(64'(b_lo_q), ml, FRAC_W, 1'b0);
		else
			nyl = -scale_product(64'(b_hi_q), ml, FRAC_W, 1'b1);
		if (xu >= 0)
			nyu = scale_product(64'(b_hi_q), mu, FRAC_W, 1'b1);
		else
			nyu = -scale_product(64'(b_lo_q), mu, FRAC_W, 1'b0);
		c0 = clamp_word(nxl);
		c1 = clamp_word(nxu);
		c2 = clamp_word(nyl);
		c3 = clamp_word(nyu);
		r.nx_lo = c0.word;
		r.nx_hi = c1.word;
		r.ny_lo = c2.word;
		r.ny_hi = c3.word;
		r.sat = c0.clip | c1.clip | c2.clip | c3.clip;
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] corner_word();
		case ($urandom_range(0, 6))
			0: return MIN_Q;
			1: return MAX_Q;
			2: return ZERO_Q;
			3: return ALL_ONES_Q;
			4: return WORD_W'(1);
			5: return ONE_Q;
			default: return NEG_ONE_Q;
		endcase
	endfunction

	function automatic box_t random_box();
		box_t b;
		int c, w, k;
		k = $urandom_range(0, 9);
		if (k < 2) begin
			b.xl = $urandom;
			b.xu = $urandom;
			b.yl = $urandom;
			b.yu = $urandom;
		end else if (k == 7) begin
			// x straddles zero
			b.xl = -int'($urandom_range(1, 1 << 29));
			b.xu = $urandom_range(1, 1 << 29);
			b.yl = -int'($urandom_range(0, 1 << 27));
			b.yu = $urandom_range(0, 1 << 27);
		end else if (k == 8) begin
			b.xl = corner_word();
			b.xu = corner_word();
			b.yl = corner_word();
			b.yu = corner_word();
		end else begin
			// small box around the attractor
			c = int'($urandom_range(0, 1 << 30)) - (1 << 29);
			w = int'($urandom_range(0, 1 << 22));
			b.xl = c;
			b.xu = c + w;
			c = int'($urandom_range(0, 1 << 28)) - (1 << 27);
			w = int'($urandom_range(0, 1 << 22));
			b.yl = c;
			b.yu = c + w;
			if (k == 9) begin
				{b.xl, b.xu} = {b.xu, b.xl};
				if ($urandom_range(0, 1))
					{b.yl, b.yu} = {b.yu, b.yl};
			end
		end
		return b;
	endfunction

	task automatic check_field(input string name, input logic [WORD_W-1:0] want_v,
			input logic [WORD_W-1:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %h, got %h", name, want_v, got_v);
			fail_count++;
		end
	endtask

	task automatic offer_box(input box_t b, input logic known, input enclosure_t want);
		int r, gap;
		in_valid <= 1'b1;
		x_lower <= b.xl;
		x_upper <= b.xu;
		y_lower <= b.yl;
		y_upper <= b.yu;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_enclosures.push_back(known ? want : henon_enclose(b));
		boxes_sent++;
		gap = 0;
		if (!calm) begin
			r = $urandom_range(0, 99);
			if (r >= 92)
				gap = $urandom_range(8, 40);
			else if (r >= 55)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (pending_enclosures.size() != 0 && waited < SETTLE_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// writes all four parameters and one unmapped index, block idle
	task automatic load_params(input logic [CFG_W-1:0] al, input logic [CFG_W-1:0] au,
			input logic [CFG_W-1:0] bl, input logic [CFG_W-1:0] bu);
		cfg_we <= 1'b1;
		cfg_index <= REG_A_LOWER;
		cfg_data <= al;
		@(posedge clk);
		cfg_index <= REG_A_UPPER;
		cfg_data <= au;
		@(posedge clk);
		cfg_index <= REG_B_LOWER;
		cfg_data <= bl;
		@(posedge clk);
		cfg_index <= REG_B_UPPER;
		cfg_data <= bu;
		@(posedge clk);
		cfg_index <= REG_UNUSED_FIRST + IDX_W'($urandom_range(0, 3));
		cfg_data <= CFG_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		a_lo_q = al;
		a_hi_q = au;
		b_lo_q = bl;
		b_hi_q = bu;
		settings_used++;
	endtask

	task automatic run_phase(input int count, input bit steady, input logic [CFG_W-1:0] al,
			input logic [CFG_W-1:0] au, input logic [CFG_W-1:0] bl,
			input logic [CFG_W-1:0] bu);
		load_params(al, au, bl, bu);
		calm = steady;
		repeat (count)
			offer_box(random_box(), 1'b0, '0);
		settle();
		calm = 1'b0;
	endtask

	// receiver: random back-pressure, long hold-off on request
	initial begin
		int r, hold;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (choke_rx) begin
				choke_rx = 1'b0;
				out_ready <= 1'b0;
				hold = CHOKE_CYCLES;
			end else if (calm || r < 55) begin
				out_ready <= 1'b1;
				hold = calm ? 1 : $urandom_range(1, 8);
			end else if (r < 93) begin
				out_ready <= 1'b0;
				hold = $urandom_range(1, 3);
			end else begin
				out_ready <= 1'b0;
				hold = $urandom_range(10, 30);
			end
			repeat (hold) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		enclosure_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_enclosures.size() == 0) begin
				$error("result item with no box pending");
				fail_count++;
			end else begin
				want = pending_enclosures.pop_front();
				boxes_checked++;
				if (saturated)
					clipped_seen++;
				check_field("next_x_lower", want.nx_lo, next_x_lower);
				check_field("next_x_upper", want.nx_hi, next_x_upper);
				check_field("next_y_lower", want.ny_lo, next_y_lower);
				check_field("next_y_upper", want.ny_hi, next_y_upper);
				check_field("saturated", WORD_W'(want.sat), WORD_W'(saturated));
			end
		end
	end

	initial begin
		logic [CFG_W-1:0] al, au, bl, bu;
		int k;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		x_lower <= '0;
		x_upper <= '0;
		y_lower <= '0;
		y_upper <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_A_LOWER;
		cfg_data <= '0;
		a_lo_q = A_LOWER_RST;
		a_hi_q = A_UPPER_RST;
		b_lo_q = B_LOWER_RST;
		b_hi_q = B_UPPER_RST;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed boxes under the reset parameters
		for (int i = 0; i < PROBE_COUNT; i++)
			offer_box(DIRECTED_PROBES[i].box, DIRECTED_PROBES[i].known,
				DIRECTED_PROBES[i].want);
		settle();

		run_phase(120, 1'b0, A_LOWER_RST, A_UPPER_RST, B_LOWER_RST, B_UPPER_RST);
		run_phase(60, 1'b1, A_LOWER_RST, A_UPPER_RST, B_LOWER_RST, B_UPPER_RST);
		run_phase(50, 1'b0, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
		run_phase(40, 1'b0, '0, '0, '0, '0);
		run_phase(40, 1'b0, CFG_MAX, '0, CFG_MAX, '0);

		// receiver holds off while boxes keep coming
		load_params(A_LOWER_RST, A_UPPER_RST, B_LOWER_RST, B_UPPER_RST);
		calm = 1'b1;
		choke_rx = 1'b1;
		repeat (60)
			offer_box(random_box(), 1'b0, '0);
		settle();
		calm = 1'b0;

		repeat (6) begin
			k = $urandom_range(0, 2);
			if (k == 0) begin
				al = CFG_W'($urandom_range(0, 1 << 29));
				au = al + CFG_W'($urandom_range(0, 1 << 16));
				bl = CFG_W'($urandom_range(0, 1 << 27));
				bu = bl + CFG_W'($urandom_range(0, 1 << 16));
			end else if (k == 1) begin
				al = CFG_W'($urandom);
				au = CFG_W'($urandom);
				bl = CFG_W'($urandom);
				bu = CFG_W'($urandom);
			end else begin
				al = $urandom_range(0, 1) ? CFG_MAX : CFG_W'($urandom);
				au = $urandom_range(0, 1) ? CFG_MAX : '0;
				bl = $urandom_range(0, 1) ? '0 : CFG_W'($urandom);
				bu = $urandom_range(0, 1) ? CFG_MAX : CFG_W'($urandom);
			end
			run_phase(40, 1'b0, al, au, bl, bu);
		end

		if (pending_enclosures.size() != 0) begin
			$error("%0d expected result items never arrived", pending_enclosures.size());
			fail_count++;
		end
		$display("checked %0d of %0d boxes over %0d parameter settings, %0d clipped",
			boxes_checked, boxes_sent, settings_used, clipped_seen);
		$display("covered corners, straddling and inverted boxes, a %0d-cycle output stall",
			CHOKE_CYCLES);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
